/* hdl/wall_follow_pd_motor_controller_macros.svh */
// ----------------------------------------------------------------------------
// wall follow pd motor controller assertion macros
// shared concurrent assertion shorthands, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef WALL_FOLLOW_PD_MOTOR_CONTROLLER_MACROS_SVH
`define WALL_FOLLOW_PD_MOTOR_CONTROLLER_MACROS_SVH

// same-cycle implication
`define WFPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WFPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wfpd_pkg.sv */
// ----------------------------------------------------------------------------
// wfpd_pkg
// types, codes and constants of the wall follow pd motor controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfpd_pkg;

    localparam int PERIOD_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] REG_PWM_PERIOD  = 3'd0;
    localparam logic [2:0] REG_TARGET      = 3'd1;
    localparam logic [2:0] REG_GAIN_P      = 3'd2;
    localparam logic [2:0] REG_GAIN_D      = 3'd3;
    localparam logic [2:0] REG_CRUISE      = 3'd4;
    localparam logic [2:0] REG_GAP         = 3'd5;
    localparam logic [2:0] REG_FRONT_STOP  = 3'd6;
    localparam logic [2:0] REG_FRONT_CLEAR = 3'd7;

    localparam logic [15:0] RST_PWM_PERIOD  = 16'd625;
    localparam logic [7:0]  RST_TARGET      = 8'd25;
    localparam logic [7:0]  RST_GAIN_P      = 8'd10;
    localparam logic [7:0]  RST_GAIN_D      = 8'd20;
    localparam logic [7:0]  RST_CRUISE      = 8'd150;
    localparam logic [9:0]  RST_GAP         = 10'd55;
    localparam logic [9:0]  RST_FRONT_STOP  = 10'd20;
    localparam logic [9:0]  RST_FRONT_CLEAR = 10'd15;

    // actions
    localparam logic [1:0] ACT_GAP    = 2'd0;
    localparam logic [1:0] ACT_SPIN   = 2'd1;
    localparam logic [1:0] ACT_FOLLOW = 2'd2;

    // wheel directions
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // remembered action
    localparam logic [1:0] LA_NONE   = 2'd0;
    localparam logic [1:0] LA_GAP    = 2'd1;
    localparam logic [1:0] LA_SPIN   = 2'd2;
    localparam logic [1:0] LA_FOLLOW = 2'd3;

    localparam logic [7:0] SPEED_MAX       = 8'd255;
    localparam logic [7:0] GAP_LEFT_SPEED  = 8'd255;
    localparam logic [7:0] GAP_RIGHT_SPEED = 8'd150;
    localparam logic [7:0] SPIN_SPEED      = 8'd200;
    localparam logic [9:0] SPIN_RIGHT_LIMIT   = 10'd25;
    localparam logic [9:0] FOLLOW_RIGHT_LIMIT = 10'd30;

    // shared multiply-accumulate widths
    localparam int MAC_A_W = 25;
    localparam int MAC_B_W = 17;
    localparam int MAC_W   = MAC_A_W + MAC_B_W;

    // floor(x / 255) for x below 2**24: (x * RECIP_255) >> RECIP_SHIFT,
    // at most one too high
    localparam int RECIP_SHIFT = 23;
    localparam logic [MAC_B_W-1:0] RECIP_255 = 17'd32897;
    localparam logic [MAC_B_W-1:0] NEG_255   = 17'h1FF01;

    typedef struct packed {
        logic [9:0] front_distance;
        logic [9:0] right_distance;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  left_dir;
        logic [15:0] left_duty;
        logic [1:0]  right_dir;
        logic [15:0] right_duty;
        logic        led_green;
    } out_item_t;

    typedef struct packed {
        logic               en;
        logic [MAC_A_W-1:0] a;
        logic [MAC_B_W-1:0] b;
        logic [MAC_W-1:0]   addend;
    } mac_req_t;

endpackage

/* hdl/wfpd_mac.sv */
// ----------------------------------------------------------------------------
// wfpd_mac
// shared signed multiply-accumulate unit with registered result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfpd_mac (
    input  logic                                  clk,
    input  wfpd_pkg::mac_req_t                    req,
    output logic signed [wfpd_pkg::MAC_W-1:0]     res
);
    import wfpd_pkg::*;

    logic signed [MAC_W-1:0] prod;
    logic signed [MAC_W-1:0] sum_next;
    logic signed [MAC_W-1:0] res_reg;

    assign prod     = $signed(req.a) * $signed(req.b);
    assign sum_next = prod + $signed(req.addend);
    assign res      = res_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            res_reg <= sum_next;
        end
    end

endmodule

/* hdl/wall_follow_pd_motor_controller.sv */
// ----------------------------------------------------------------------------
// wall_follow_pd_motor_controller
// right-hand wall follower: picks gap turn, left spin or pd wall following
// from one distance pair and produces wheel directions and pwm duties
// ----------------------------------------------------------------------------
//  channel | signals                         | transfer
//  in      | in_valid, in_stall, in_data     | valid high and stall low
//  out     | out_valid, out_stall, out_data  | valid high and stall low
//  cfg     | cfg_valid, cfg_ready, cfg_index,| valid and ready high
//          | cfg_data                        |
//
//  one transaction at a time through a single shared multiply-accumulate unit
//  gap turn or spin: decide, then multiply, reciprocal, fix and set per wheel duty
//  wall follow: as above, adding the p term, d term and correction steps
//  no matching rule: back to idle after the decide step and no result
//  a finished result waits in the output register; the next transaction is
//  taken meanwhile, and the sequencer holds only if a second result is ready
//  reset restores the register defaults and forgets the last action
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wall_follow_pd_motor_controller_macros.svh"

module wall_follow_pd_motor_controller #(
    parameter int PERIOD_BITS = wfpd_pkg::PERIOD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wfpd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output wfpd_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import wfpd_pkg::*;

    localparam int PW = (PERIOD_BITS < 16) ? PERIOD_BITS : 16;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECIDE   = 4'd1;
    localparam logic [3:0] ST_MUL_P    = 4'd2;
    localparam logic [3:0] ST_MUL_D    = 4'd3;
    localparam logic [3:0] ST_CORR     = 4'd4;
    localparam logic [3:0] ST_DUTY_MUL = 4'd5;
    localparam logic [3:0] ST_DUTY_RCP = 4'd6;
    localparam logic [3:0] ST_DUTY_FIX = 4'd7;
    localparam logic [3:0] ST_DUTY_SET = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    // configuration
    logic [PW-1:0] pwm_period_reg;
    logic [7:0]    target_reg;
    logic [7:0]    gain_p_reg;
    logic [7:0]    gain_d_reg;
    logic [7:0]    cruise_reg;
    logic [9:0]    gap_reg;
    logic [9:0]    front_stop_reg;
    logic [9:0]    front_clear_reg;

    // sequencer and working registers
    logic [3:0]         state_reg, state_next;
    logic [1:0]         last_action_reg, last_action_next;
    logic signed [11:0] prev_err_reg, prev_err_next;
    logic [9:0]         front_reg, front_next;
    logic [9:0]         right_reg, right_next;
    logic signed [12:0] err_reg, err_next;
    logic [1:0]         act_reg, act_next;
    logic [7:0]         ls_reg, ls_next;
    logic [7:0]         rs_reg, rs_next;
    logic [1:0]         lcmd_reg, lcmd_next;
    logic [1:0]         rcmd_reg, rcmd_next;
    logic               wheel_sel_reg, wheel_sel_next;
    logic [23:0]        x_reg, x_next;
    logic [16:0]        q_reg, q_next;
    logic [1:0]         ldir_reg, ldir_next;
    logic [15:0]        lduty_reg, lduty_next;
    logic [1:0]         rdir_reg, rdir_next;
    logic [15:0]        rduty_reg, rduty_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    mac_req_t                mac_req;
    logic signed [MAC_W-1:0] mac_res;

    logic signed [13:0] derr;
    logic signed [19:0] c2;
    logic signed [19:0] corr;
    logic signed [19:0] lsum;
    logic signed [19:0] rsum;
    logic [7:0]         speed_cur;
    logic [1:0]         cmd_cur;
    logic [16:0]        q_fixed;
    logic [15:0]        period_ext;
    logic               out_free;

    wfpd_mac u_mac (
        .clk (clk),
        .req (mac_req),
        .res (mac_res)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign period_ext = 16'(pwm_period_reg);
    assign derr       = 14'(err_reg) - 14'(prev_err_reg);
    // truncation toward zero of the halved correction
    assign c2         = mac_res[19:0];
    assign corr       = (c2 + $signed({19'd0, c2[19]})) >>> 1;
    assign lsum       = $signed({12'd0, cruise_reg}) - corr;
    assign rsum       = $signed({12'd0, cruise_reg}) + corr;
    assign speed_cur  = wheel_sel_reg ? rs_reg : ls_reg;
    assign cmd_cur    = wheel_sel_reg ? rcmd_reg : lcmd_reg;
    assign q_fixed    = mac_res[MAC_W-1] ? (q_reg - 17'd1) : q_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // shared unit operand selection
    always_comb
    begin
        mac_req        = '0;
        mac_req.addend = '0;
        unique case (state_reg)
            ST_MUL_P:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MAC_A_W'(err_reg);
                mac_req.b  = {9'd0, gain_p_reg};
            end
            ST_MUL_D:
            begin
                mac_req.en     = 1'b1;
                mac_req.a      = MAC_A_W'(derr);
                mac_req.b      = (last_action_reg == LA_FOLLOW) ? {9'd0, gain_d_reg} : '0;
                mac_req.addend = mac_res;
            end
            ST_DUTY_MUL:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = {17'd0, speed_cur};
                mac_req.b  = {1'b0, period_ext};
            end
            ST_DUTY_RCP:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = {1'b0, mac_res[23:0]};
                mac_req.b  = RECIP_255;
            end
            ST_DUTY_FIX:
            begin
                // remainder x - 255 * q_est, negative when the estimate is high
                mac_req.en     = 1'b1;
                mac_req.a      = {8'd0, mac_res[RECIP_SHIFT+16:RECIP_SHIFT]};
                mac_req.b      = NEG_255;
                mac_req.addend = {18'd0, x_reg};
            end
            default:
            begin
                mac_req.en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        last_action_next = last_action_reg;
        prev_err_next    = prev_err_reg;
        front_next       = front_reg;
        right_next       = right_reg;
        err_next         = err_reg;
        act_next         = act_reg;
        ls_next          = ls_reg;
        rs_next          = rs_reg;
        lcmd_next        = lcmd_reg;
        rcmd_next        = rcmd_reg;
        wheel_sel_next   = wheel_sel_reg;
        x_next           = x_reg;
        q_next           = q_reg;
        ldir_next        = ldir_reg;
        lduty_next       = lduty_reg;
        rdir_next        = rdir_reg;
        rduty_next       = rduty_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    front_next = in_data.front_distance;
                    right_next = in_data.right_distance;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                wheel_sel_next = 1'b0;
                err_next = $signed({5'd0, target_reg}) - $signed({2'd0, right_reg, 1'b0});
                if (right_reg >= gap_reg)
                begin
                    act_next         = ACT_GAP;
                    ls_next          = GAP_LEFT_SPEED;
                    rs_next          = GAP_RIGHT_SPEED;
                    lcmd_next        = DIR_FWD;
                    rcmd_next        = DIR_FWD;
                    last_action_next = LA_GAP;
                    state_next       = ST_DUTY_MUL;
                end
                else if ((front_reg <= front_stop_reg) && (right_reg <= SPIN_RIGHT_LIMIT))
                begin
                    act_next         = ACT_SPIN;
                    ls_next          = SPIN_SPEED;
                    rs_next          = SPIN_SPEED;
                    lcmd_next        = DIR_REV;
                    rcmd_next        = DIR_FWD;
                    last_action_next = LA_SPIN;
                    state_next       = ST_DUTY_MUL;
                end
                else if ((front_reg >= front_clear_reg) && (right_reg < FOLLOW_RIGHT_LIMIT))
                begin
                    act_next   = ACT_FOLLOW;
                    lcmd_next  = DIR_FWD;
                    rcmd_next  = DIR_FWD;
                    state_next = ST_MUL_P;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL_P:
            begin
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                // d term reads the old state in this cycle
                prev_err_next    = err_reg[11:0];
                last_action_next = LA_FOLLOW;
                state_next       = ST_CORR;
            end
            ST_CORR:
            begin
                if (lsum[19])
                begin
                    ls_next = '0;
                end
                else if (lsum > $signed({12'd0, SPEED_MAX}))
                begin
                    ls_next = SPEED_MAX;
                end
                else
                begin
                    ls_next = lsum[7:0];
                end
                if (rsum[19])
                begin
                    rs_next = '0;
                end
                else if (rsum > $signed({12'd0, SPEED_MAX}))
                begin
                    rs_next = SPEED_MAX;
                end
                else
                begin
                    rs_next = rsum[7:0];
                end
                state_next = ST_DUTY_MUL;
            end
            ST_DUTY_MUL:
            begin
                state_next = ST_DUTY_RCP;
            end
            ST_DUTY_RCP:
            begin
                x_next     = mac_res[23:0];
                state_next = ST_DUTY_FIX;
            end
            ST_DUTY_FIX:
            begin
                q_next     = mac_res[RECIP_SHIFT+16:RECIP_SHIFT];
                state_next = ST_DUTY_SET;
            end
            ST_DUTY_SET:
            begin
                if (wheel_sel_reg)
                begin
                    rdir_next  = (speed_cur == 8'd0) ? DIR_STOP : cmd_cur;
                    rduty_next = (speed_cur == 8'd0) ? 16'd1 : q_fixed[15:0];
                    state_next = ST_DONE;
                end
                else
                begin
                    ldir_next      = (speed_cur == 8'd0) ? DIR_STOP : cmd_cur;
                    lduty_next     = (speed_cur == 8'd0) ? 16'd1 : q_fixed[15:0];
                    wheel_sel_next = 1'b1;
                    state_next     = ST_DUTY_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.action     = act_reg;
                    out_data_next.left_dir   = ldir_reg;
                    out_data_next.left_duty  = lduty_reg;
                    out_data_next.right_dir  = rdir_reg;
                    out_data_next.right_duty = rduty_reg;
                    out_data_next.led_green  = (act_reg == ACT_FOLLOW);
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_action_reg <= LA_NONE;
            prev_err_reg    <= '0;
            out_valid_reg   <= 1'b0;
            pwm_period_reg  <= RST_PWM_PERIOD[PW-1:0];
            target_reg      <= RST_TARGET;
            gain_p_reg      <= RST_GAIN_P;
            gain_d_reg      <= RST_GAIN_D;
            cruise_reg      <= RST_CRUISE;
            gap_reg         <= RST_GAP;
            front_stop_reg  <= RST_FRONT_STOP;
            front_clear_reg <= RST_FRONT_CLEAR;
        end
        else
        begin
            state_reg       <= state_next;
            last_action_reg <= last_action_next;
            prev_err_reg    <= prev_err_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PWM_PERIOD:  pwm_period_reg  <= cfg_data[PW-1:0];
                    REG_TARGET:      target_reg      <= cfg_data[7:0];
                    REG_GAIN_P:      gain_p_reg      <= cfg_data[7:0];
                    REG_GAIN_D:      gain_d_reg      <= cfg_data[7:0];
                    REG_CRUISE:      cruise_reg      <= cfg_data[7:0];
                    REG_GAP:         gap_reg         <= cfg_data[9:0];
                    REG_FRONT_STOP:  front_stop_reg  <= cfg_data[9:0];
                    REG_FRONT_CLEAR: front_clear_reg <= cfg_data[9:0];
                    default:         gap_reg         <= gap_reg;
                endcase
            end
        end
    end

    // working payload, no reset
    always_ff @(posedge clk)
    begin
        front_reg     <= front_next;
        right_reg     <= right_next;
        err_reg       <= err_next;
        act_reg       <= act_next;
        ls_reg        <= ls_next;
        rs_reg        <= rs_next;
        lcmd_reg      <= lcmd_next;
        rcmd_reg      <= rcmd_next;
        wheel_sel_reg <= wheel_sel_next;
        x_reg         <= x_next;
        q_reg         <= q_next;
        ldir_reg      <= ldir_next;
        lduty_reg     <= lduty_next;
        rdir_reg      <= rdir_next;
        rduty_reg     <= rduty_next;
        out_data_reg  <= out_data_next;
    end

    `WFPD_ASSERT_NXT(a_accept_starts_decide, in_valid && !in_stall, state_reg == ST_DECIDE, "accepted transaction did not start the sequencer")
    `WFPD_ASSERT_NXT(a_done_waits, (state_reg == ST_DONE) && out_valid_reg && out_stall, (state_reg == ST_DONE) && $stable(out_data_reg), "pending result overwritten")
    `WFPD_ASSERT_IMP(a_load_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE), "result appeared outside the done step")
    `WFPD_ASSERT_IMP(a_left_stop_duty, out_valid_reg && (out_data_reg.left_dir == DIR_STOP), out_data_reg.left_duty == 16'd1, "stopped left wheel without unit duty")
    `WFPD_ASSERT_IMP(a_right_stop_duty, out_valid_reg && (out_data_reg.right_dir == DIR_STOP), out_data_reg.right_duty == 16'd1, "stopped right wheel without unit duty")

endmodule
